>>> rtl/dsa_pkg.sv
// Shared constants, codes and types of the descriptor slot allocator.
`default_nettype none

package dsa_pkg;

    // Pool size and derived widths.
    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = SLOT_W + 1;
    localparam int HANDLE_W = 64;
    localparam int SIZE_W   = 13;
    localparam int SPAN_W   = COUNT_W + SIZE_W;
    localparam int STEP_W   = $clog2(SLOT_W);
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DESC_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHADER_VIS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0]  DESC_SIZE_RST = 13'd32;
    localparam logic [COUNT_W-1:0] NUM_SLOTS_RST = 11'd1024;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_FREED = 2'd3
    } status_t;

    // Request to the iterative divider.
    typedef struct packed {
        logic              start;
        logic [SPAN_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    // Status of the iterative divider.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SLOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/dsa_channels.sv
// Request and response channel interfaces of the descriptor slot allocator.
`default_nettype none

interface dsa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [dsa_pkg::HANDLE_W-1:0] cpu_handle;

    modport source (output valid, output mode, output cpu_handle, input ready);
    modport sink   (input valid, input mode, input cpu_handle, output ready);
endinterface

interface dsa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dsa_pkg::STATUS_W-1:0] status;
    logic [dsa_pkg::HANDLE_W-1:0] slot_cpu_handle;
    logic [dsa_pkg::HANDLE_W-1:0] slot_gpu_handle;
    logic [dsa_pkg::SLOT_W-1:0]   slot_number;

    modport source (output valid, output status, output slot_cpu_handle,
                    output slot_gpu_handle, output slot_number, input ready);
    modport sink   (input valid, input status, input slot_cpu_handle,
                    input slot_gpu_handle, input slot_number, output ready);
endinterface

`default_nettype wire

>>> rtl/descriptor_slot_allocator.sv
// Descriptor slot allocator: hands out and takes back descriptor slots as CPU/GPU handles.
//
// Requests arrive on req (mode 0 allocates, mode 1 frees cpu_handle); every request
// gives exactly one transfer on rsp with a status, the slot handles and the slot number.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while idle, which the block does not enforce. The free list
// lives in two memories: a stack of returned slots and an allocated map. One request
// is worked on at a time. An allocate of a fresh slot goes through a multiply and an
// add, one of a returned slot first reads the stack, and an allocate on an empty list
// goes straight to the output. A free subtracts the base, checks the range, runs the
// divider that turns the handle offset into a slot one bit per cycle, reads the map
// and does the update; a handle out of range is answered after the range check. The
// next request is taken the cycle after a result is registered, even while that result
// still waits on rsp. If rsp stalls with a result pending, the following result is held
// inside until the output register drains, and no new request is taken meanwhile.
// After reset, and after every write of num_slots, the allocated map is cleared in
// a pass over every slot during which no request is taken.
`default_nettype none

module descriptor_slot_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dsa_req_if.sink                            req,
    dsa_rsp_if.source                          rsp,
    input  wire logic                          cfg_we,
    input  wire logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dsa_pkg::HANDLE_W-1:0]  cfg_wdata
);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_POP   = 11'b000_0000_0100,
        S_MUL   = 11'b000_0000_1000,
        S_ADD   = 11'b000_0001_0000,
        S_SUB   = 11'b000_0010_0000,
        S_CMP   = 11'b000_0100_0000,
        S_DIV   = 11'b000_1000_0000,
        S_MAPRD = 11'b001_0000_0000,
        S_CHECK = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    // Configuration registers.
    logic [dsa_pkg::HANDLE_W-1:0] cpu_base_reg;
    logic [dsa_pkg::HANDLE_W-1:0] gpu_base_reg;
    logic [dsa_pkg::SIZE_W-1:0]   desc_size_reg;
    logic                         shader_vis_reg;
    logic [dsa_pkg::COUNT_W-1:0]  num_slots_reg;

    // Control state.
    state_t                       state_reg, state_next;
    logic [dsa_pkg::COUNT_W-1:0]  ret_count_reg, ret_count_next;
    logic [dsa_pkg::COUNT_W-1:0]  fresh_reg, fresh_next;
    logic [dsa_pkg::SLOT_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    // Working and result registers.
    logic [dsa_pkg::HANDLE_W-1:0] handle_reg, handle_next;
    logic [dsa_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [dsa_pkg::SPAN_W-1:0]   offset_reg, offset_next;
    logic [dsa_pkg::HANDLE_W-1:0] diff_reg, diff_next;
    logic [dsa_pkg::SPAN_W-1:0]   span_reg, span_next;
    logic                         below_reg, below_next;
    dsa_pkg::status_t             res_status_reg, res_status_next;
    logic [dsa_pkg::HANDLE_W-1:0] res_cpu_reg, res_cpu_next;
    logic [dsa_pkg::HANDLE_W-1:0] res_gpu_reg, res_gpu_next;
    logic [dsa_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [dsa_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [dsa_pkg::HANDLE_W-1:0] rsp_cpu_reg;
    logic [dsa_pkg::HANDLE_W-1:0] rsp_gpu_reg;
    logic [dsa_pkg::SLOT_W-1:0]   rsp_slot_reg;
    logic                         rsp_load;

    // Derived configuration values.
    logic [dsa_pkg::SIZE_W-1:0]   stride;
    logic [dsa_pkg::COUNT_W-1:0]  limit;

    // Memory ports.
    logic                         stack_we;
    logic [dsa_pkg::SLOT_W-1:0]   stack_waddr;
    logic                         stack_re;
    logic [dsa_pkg::SLOT_W-1:0]   stack_raddr;
    logic [dsa_pkg::SLOT_W-1:0]   stack_rdata;
    logic                         map_we;
    logic [dsa_pkg::SLOT_W-1:0]   map_waddr;
    logic                         map_wdata;
    logic                         map_re;
    logic                         map_rdata;

    // Divider link.
    dsa_pkg::div_req_t            div_req;
    dsa_pkg::div_rsp_t            div_rsp;

    logic                         req_fire;
    logic                         restart;

    assign stride = (desc_size_reg == '0) ? dsa_pkg::SIZE_W'(1) : desc_size_reg;
    assign limit  = (num_slots_reg > dsa_pkg::COUNT_W'(dsa_pkg::CAPACITY))
                    ? dsa_pkg::COUNT_W'(dsa_pkg::CAPACITY) : num_slots_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && (state_reg == S_IDLE);
    assign restart   = cfg_we && (cfg_index == dsa_pkg::REG_NUM_SLOTS);

    // Stack of slots returned by frees.
    dsa_ram #(
        .WIDTH (dsa_pkg::SLOT_W),
        .DEPTH (dsa_pkg::CAPACITY)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (slot_reg),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // One bit per slot, set while the slot is handed out.
    dsa_ram #(
        .WIDTH (1),
        .DEPTH (dsa_pkg::CAPACITY)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (slot_reg),
        .rdata (map_rdata)
    );

    // Handle offset to slot number.
    dsa_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        ret_count_next  = ret_count_reg;
        fresh_next      = fresh_reg;
        clr_addr_next   = clr_addr_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_load        = 1'b0;
        handle_next     = handle_reg;
        slot_next       = slot_reg;
        offset_next     = offset_reg;
        diff_next       = diff_reg;
        span_next       = span_reg;
        below_next      = below_reg;
        res_status_next = res_status_reg;
        res_cpu_next    = res_cpu_reg;
        res_gpu_next    = res_gpu_reg;
        res_slot_next   = res_slot_reg;
        stack_we        = 1'b0;
        stack_waddr     = ret_count_reg[dsa_pkg::SLOT_W-1:0];
        stack_re        = 1'b0;
        stack_raddr     = ret_count_reg[dsa_pkg::SLOT_W-1:0] - 1'b1;
        map_we          = 1'b0;
        map_waddr       = slot_reg;
        map_wdata       = 1'b0;
        map_re          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = diff_reg[dsa_pkg::SPAN_W-1:0];
        div_req.divisor  = stride;

        case (state_reg)
            S_CLEAR:
            begin
                map_we        = 1'b1;
                map_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == dsa_pkg::SLOT_W'(dsa_pkg::CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.mode == dsa_pkg::MODE_FREE)
                    begin
                        handle_next = req.cpu_handle;
                        state_next  = S_SUB;
                    end
                    else if (ret_count_reg != '0)
                    begin
                        // Pop the most recently returned slot.
                        stack_re       = 1'b1;
                        ret_count_next = ret_count_reg - 1'b1;
                        state_next     = S_POP;
                    end
                    else if (fresh_reg < limit)
                    begin
                        slot_next  = fresh_reg[dsa_pkg::SLOT_W-1:0];
                        fresh_next = fresh_reg + 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_status_next = dsa_pkg::STAT_EMPTY;
                        res_cpu_next    = '0;
                        res_gpu_next    = '0;
                        res_slot_next   = '0;
                        state_next      = S_OUT;
                    end
                end
            end
            S_POP:
            begin
                slot_next  = stack_rdata;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // Mark the slot handed out and form its byte offset.
                map_we      = 1'b1;
                map_wdata   = 1'b1;
                offset_next = dsa_pkg::SPAN_W'(slot_reg) * dsa_pkg::SPAN_W'(stride);
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                res_status_next = dsa_pkg::STAT_OK;
                res_cpu_next    = cpu_base_reg + dsa_pkg::HANDLE_W'(offset_reg);
                res_gpu_next    = shader_vis_reg
                                  ? (gpu_base_reg + dsa_pkg::HANDLE_W'(offset_reg)) : '0;
                res_slot_next   = slot_reg;
                state_next      = S_OUT;
            end
            S_SUB:
            begin
                below_next = (handle_reg < cpu_base_reg);
                diff_next  = handle_reg - cpu_base_reg;
                span_next  = dsa_pkg::SPAN_W'(limit) * dsa_pkg::SPAN_W'(stride);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // The offset must lie below limit * stride for a valid slot.
                if (below_reg || (diff_reg >= dsa_pkg::HANDLE_W'(span_reg)))
                begin
                    res_status_next = dsa_pkg::STAT_RANGE;
                    res_cpu_next    = '0;
                    res_gpu_next    = '0;
                    res_slot_next   = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    slot_next  = div_rsp.quotient;
                    state_next = S_MAPRD;
                end
            end
            S_MAPRD:
            begin
                map_re     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_cpu_next = '0;
                res_gpu_next = '0;
                if (!map_rdata
                    || (ret_count_reg >= dsa_pkg::COUNT_W'(dsa_pkg::CAPACITY)))
                begin
                    res_status_next = dsa_pkg::STAT_FREED;
                    res_slot_next   = '0;
                end
                else
                begin
                    // Clear the map bit and push the slot.
                    map_we          = 1'b1;
                    stack_we        = 1'b1;
                    ret_count_next  = ret_count_reg + 1'b1;
                    res_status_next = dsa_pkg::STAT_OK;
                    res_slot_next   = slot_reg;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // A new slot count empties the free list and starts a clearing pass.
        if (restart)
        begin
            state_next     = S_CLEAR;
            clr_addr_next  = '0;
            ret_count_next = '0;
            fresh_next     = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ret_count_reg <= '0;
            fresh_reg     <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_count_reg <= ret_count_next;
            fresh_reg     <= fresh_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_base_reg   <= '0;
            gpu_base_reg   <= '0;
            desc_size_reg  <= dsa_pkg::DESC_SIZE_RST;
            shader_vis_reg <= 1'b0;
            num_slots_reg  <= dsa_pkg::NUM_SLOTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsa_pkg::REG_CPU_BASE:   cpu_base_reg   <= cfg_wdata;
                dsa_pkg::REG_GPU_BASE:   gpu_base_reg   <= cfg_wdata;
                dsa_pkg::REG_DESC_SIZE:  desc_size_reg  <= cfg_wdata[dsa_pkg::SIZE_W-1:0];
                dsa_pkg::REG_SHADER_VIS: shader_vis_reg <= cfg_wdata[0];
                dsa_pkg::REG_NUM_SLOTS:  num_slots_reg  <= cfg_wdata[dsa_pkg::COUNT_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        handle_reg     <= handle_next;
        slot_reg       <= slot_next;
        offset_reg     <= offset_next;
        diff_reg       <= diff_next;
        span_reg       <= span_next;
        below_reg      <= below_next;
        res_status_reg <= res_status_next;
        res_cpu_reg    <= res_cpu_next;
        res_gpu_reg    <= res_gpu_next;
        res_slot_reg   <= res_slot_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_cpu_reg    <= res_cpu_reg;
            rsp_gpu_reg    <= res_gpu_reg;
            rsp_slot_reg   <= res_slot_reg;
        end
    end

    // Output register drives the response channel.
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.slot_cpu_handle = rsp_cpu_reg;
    assign rsp.slot_gpu_handle = rsp_gpu_reg;
    assign rsp.slot_number     = rsp_slot_reg;

endmodule

`default_nettype wire

>>> rtl/dsa_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module dsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/dsa_divider.sv
// Restoring divider that yields one quotient bit per cycle for handle-to-slot conversion.
`default_nettype none

module dsa_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsa_pkg::div_req_t req,
    output dsa_pkg::div_rsp_t      rsp
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [dsa_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [dsa_pkg::SPAN_W-1:0]   rem_reg, rem_next;
    logic [dsa_pkg::SPAN_W-1:0]   dsh_reg, dsh_next;
    logic [dsa_pkg::SLOT_W-1:0]   quo_reg, quo_next;
    logic                         fits;

    // One compare and subtract per cycle, divisor walking right.
    always_comb
    begin
        fits      = (rem_reg >= dsh_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = dsa_pkg::STEP_W'(dsa_pkg::SLOT_W - 1);
            rem_next  = req.dividend;
            dsh_next  = dsa_pkg::SPAN_W'(req.divisor) << (dsa_pkg::SLOT_W - 1);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? (rem_reg - dsh_reg) : rem_reg;
            quo_next  = {quo_reg[dsa_pkg::SLOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> tb/descriptor_slot_allocator_test.sv
// Self-checking testbench of the descriptor slot allocator with a built-in free-list predictor.
module descriptor_slot_allocator_test;

    import dsa_pkg::*;

    // A cycle with no transfer on either channel counts toward this limit.
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;

    // The predictor keeps two copies of the pool: one advanced at each accepted
    // request, one advanced while the stimulus is planned.
    localparam int LIVE = 0;
    localparam int PLAN = 1;

    localparam logic [HANDLE_W-1:0] DIR_BASE = 64'hFFFF_FFFF_FFFE_0000;
    localparam logic [HANDLE_W-1:0] DIR_STEP = 64'd4096;

    typedef struct packed {
        logic                mode;
        logic [HANDLE_W-1:0] handle;
    } slot_request_t;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] cpu_handle;
        logic [HANDLE_W-1:0] gpu_handle;
        logic [SLOT_W-1:0]   slot;
    } slot_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Signals driven into the block.
    logic                 offer_valid = 1'b0;
    slot_request_t        offer = '0;
    logic                 take_ready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CPU_BASE;
    logic [HANDLE_W-1:0]  cfg_wdata = '0;

    // Register values as the predictor sees them.
    logic [HANDLE_W-1:0] base_cpu = '0;
    logic [HANDLE_W-1:0] base_gpu = '0;
    logic [SIZE_W-1:0]   desc_size = DESC_SIZE_RST;
    logic                shader_vis = 1'b0;
    logic [COUNT_W-1:0]  slots_cfg = NUM_SLOTS_RST;

    // Free-list state: returned slots stacked over a fresh-slot counter.
    logic [SLOT_W-1:0] returned_slots [2][CAPACITY];
    int                returned_depth [2];
    int                fresh_next [2];
    bit                slot_taken [2][CAPACITY];

    slot_request_t pending_requests [$];
    slot_reply_t   due_replies [$];
    int            held_slots [$];

    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    dsa_req_if req_ch ();
    dsa_rsp_if rsp_ch ();

    assign req_ch.valid      = offer_valid;
    assign req_ch.mode       = offer.mode;
    assign req_ch.cpu_handle = offer.handle;
    assign rsp_ch.ready      = take_ready;

    descriptor_slot_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pool_limit();
        return (slots_cfg > CAPACITY) ? CAPACITY : int'(slots_cfg);
    endfunction

    // A zero descriptor size behaves as a stride of one byte.
    function automatic logic [HANDLE_W-1:0] stride();
        return (desc_size == '0) ? 64'd1 : 64'(desc_size);
    endfunction

    function automatic logic [HANDLE_W-1:0] slot_handle(input int s);
        return base_cpu + 64'(s) * stride();
    endfunction

    function automatic void clear_pool(input int c);
        returned_depth[c] = 0;
        fresh_next[c] = 0;
        for (int i = 0; i < CAPACITY; i++)
            slot_taken[c][i] = 1'b0;
    endfunction

    // Expected reply of one request; updates the chosen copy of the pool.
    function automatic slot_reply_t serve_request(input int c, input slot_request_t r);
        slot_reply_t         rep;
        logic [HANDLE_W-1:0] quot;
        int                  lim;
        int                  s;
        bit                  got;
        rep = '0;
        rep.status = STAT_OK;
        lim = pool_limit();
        got = 1'b0;
        s = 0;
        if (r.mode == MODE_ALLOC)
        begin
            // Returned slots sit above the fresh ones on the free stack.
            if (returned_depth[c] > 0)
            begin
                returned_depth[c]--;
                s = int'(returned_slots[c][returned_depth[c]]);
                got = 1'b1;
            end
            else if (fresh_next[c] < lim)
            begin
                s = fresh_next[c];
                fresh_next[c]++;
                got = 1'b1;
            end
            if (got)
            begin
                slot_taken[c][s] = 1'b1;
                rep.slot = s[SLOT_W-1:0];
                rep.cpu_handle = slot_handle(s);
                if (shader_vis)
                    rep.gpu_handle = base_gpu + 64'(s) * stride();
            end
            else
                rep.status = STAT_EMPTY;
        end
        else if (r.handle < base_cpu)
            rep.status = STAT_RANGE;
        else
        begin
            // The whole quotient is range checked; an unaligned handle rounds down.
            quot = (r.handle - base_cpu) / stride();
            if (quot >= 64'(lim))
                rep.status = STAT_RANGE;
            else if (!slot_taken[c][quot[SLOT_W-1:0]])
                rep.status = STAT_FREED;
            else
            begin
                s = int'(quot);
                slot_taken[c][s] = 1'b0;
                returned_slots[c][returned_depth[c]] = s[SLOT_W-1:0];
                returned_depth[c]++;
                rep.slot = s[SLOT_W-1:0];
            end
        end
        return rep;
    endfunction

    // Queue one request and keep the list of slots that the plan holds current.
    function automatic void queue_item(input logic mode, input logic [HANDLE_W-1:0] h);
        slot_request_t r;
        slot_reply_t   rep;
        r.mode = mode;
        r.handle = h;
        rep = serve_request(PLAN, r);
        if (rep.status == STAT_OK)
        begin
            if (mode == MODE_ALLOC)
                held_slots.insert(held_slots.size(), int'(rep.slot));
            else
            begin
                for (int i = 0; i < held_slots.size(); i++)
                begin
                    if (held_slots[i] == int'(rep.slot))
                    begin
                        held_slots.delete(i);
                        break;
                    end
                end
            end
        end
        pending_requests.insert(pending_requests.size(), r);
    endfunction

    // Mostly allocations and frees of held handles, the rest frees of random or altered handles.
    function automatic void queue_random();
        logic [HANDLE_W-1:0] h;
        int                  roll;
        int                  pick;
        roll = $urandom_range(99);
        h = {$urandom, $urandom};
        pick = (held_slots.size() != 0) ? held_slots[$urandom_range(held_slots.size() - 1)] : 0;
        if (roll < 45 || (roll < 85 && held_slots.size() == 0))
            queue_item(MODE_ALLOC, h);
        else if (roll < 85)
            queue_item(MODE_FREE, slot_handle(pick) + 64'($urandom_range(int'(stride()) - 1)));
        else
        begin
            case ($urandom_range(3))
                0: ;
                1: h = slot_handle($urandom_range(pool_limit() + 1))
                       + 64'($urandom_range(int'(stride()) - 1));
                2: h = base_cpu - 64'd1 - 64'($urandom_range(99));
                default: h = slot_handle(pick) ^ (64'd1 << $urandom_range(63));
            endcase
            queue_item(MODE_FREE, h);
        end
    endfunction

    function automatic void check_field(input string name, input logic [HANDLE_W-1:0] want,
                                        input logic [HANDLE_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endfunction

    // One register write per clock; the predictor takes the new value at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HANDLE_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CPU_BASE:   base_cpu = val;
            REG_GPU_BASE:   base_gpu = val;
            REG_DESC_SIZE:  desc_size = val[SIZE_W-1:0];
            REG_SHADER_VIS: shader_vis = val[0];
            REG_NUM_SLOTS:
            begin
                slots_cfg = val[COUNT_W-1:0];
                clear_pool(LIVE);
                clear_pool(PLAN);
                held_slots.delete();
            end
            default: ;
        endcase
    endtask

    task automatic set_up(input logic [HANDLE_W-1:0] cpu, input logic [HANDLE_W-1:0] gpu,
                          input logic [SIZE_W-1:0] size, input logic vis, input bit restart,
                          input logic [COUNT_W-1:0] slots, input int send_pct,
                          input int recv_pct);
        write_reg(REG_CPU_BASE, cpu);
        write_reg(REG_GPU_BASE, gpu);
        write_reg(REG_DESC_SIZE, 64'(size));
        write_reg(REG_SHADER_VIS, 64'(vis));
        if (restart)
            write_reg(REG_NUM_SLOTS, 64'(slots));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_idle = send_pct;
        recv_idle = recv_pct;
    endtask

    // Wait until every queued request is answered, then let the block go quiet.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || offer_valid || due_replies.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    // Request driver: a transfer records the expected reply.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offer_valid <= 1'b0;
        else
        begin
            if (offer_valid && req_ch.ready)
                due_replies.insert(due_replies.size(), serve_request(LIVE, offer));
            if (!offer_valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    offer <= pending_requests.pop_front();
                    offer_valid <= 1'b1;
                end
                else
                    offer_valid <= 1'b0;
            end
        end
    end

    // Reply monitor: each transfer is checked against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        slot_reply_t want;
        if (!rst_n)
            take_ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && take_ready)
            begin
                if (due_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("reply with no request waiting: status %0d slot %0d",
                                 rsp_ch.status, rsp_ch.slot_number);
                end
                else
                begin
                    want = due_replies.pop_front();
                    check_field("status", 64'(want.status), 64'(rsp_ch.status));
                    check_field("slot_cpu_handle", want.cpu_handle, rsp_ch.slot_cpu_handle);
                    check_field("slot_gpu_handle", want.gpu_handle, rsp_ch.slot_gpu_handle);
                    check_field("slot_number", 64'(want.slot), 64'(rsp_ch.slot_number));
                end
            end
            take_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((offer_valid && req_ch.ready) || (rsp_ch.valid && take_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("descriptor_slot_allocator_test NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Three slots at a stride of 4096, GPU handles wrapping past the top.
        set_up(DIR_BASE, '1, 13'd4096, 1'b1, 1'b1, 11'd3, 25, 67);
        queue_item(MODE_FREE, 64'd0);
        queue_item(MODE_FREE, '1);
        queue_item(MODE_FREE, DIR_BASE);
        repeat (4) queue_item(MODE_ALLOC, {$urandom, $urandom});
        queue_item(MODE_FREE, DIR_BASE + DIR_STEP + 64'd7);
        queue_item(MODE_FREE, DIR_BASE + DIR_STEP);
        queue_item(MODE_FREE, DIR_BASE + 3 * DIR_STEP);
        queue_item(MODE_FREE, DIR_BASE + 3 * DIR_STEP - 64'd1);
        queue_item(MODE_FREE, DIR_BASE);
        repeat (4) queue_item(MODE_ALLOC, '0);
        queue_item(MODE_FREE, DIR_BASE + 2 * DIR_STEP);
        settle();

        // Small pool at unit stride, so it runs dry often.
        set_up({$urandom, $urandom}, {$urandom, $urandom}, 13'd1, 1'b1, 1'b1, 11'd8, 25, 67);
        repeat (120) queue_random();
        settle();

        // Full pool at zero bases without GPU handles.
        set_up('0, '0, 13'd4096, 1'b0, 1'b1, 11'd1024, 25, 67);
        repeat (150) queue_random();
        settle();

        // Single slot at the top of the address space with a zero size.
        set_up('1, {$urandom, $urandom}, 13'd0, 1'b1, 1'b1, 11'd1, 67, 25);
        queue_item(MODE_FREE, '1);
        queue_item(MODE_ALLOC, '1);
        queue_item(MODE_FREE, '1);
        queue_item(MODE_FREE, 64'hFFFF_FFFF_FFFF_FFFE);
        repeat (60) queue_random();
        settle();

        // Slot count above the pool size, widest size field.
        set_up({1'b0, $urandom, 31'($urandom)}, '1, 13'd8191, 1'b1, 1'b1, 11'd2047, 67, 25);
        queue_item(MODE_FREE, slot_handle(CAPACITY - 1));
        queue_item(MODE_FREE, slot_handle(CAPACITY));
        repeat (150) queue_random();
        settle();

        // No slots at all: every allocation finds the list empty.
        set_up({$urandom, $urandom}, {$urandom, $urandom}, SIZE_W'($urandom_range(1, 4096)),
               1'b1, 1'b1, 11'd0, 67, 25);
        queue_item(MODE_ALLOC, {$urandom, $urandom});
        queue_item(MODE_FREE, base_cpu);
        repeat (40) queue_random();
        settle();

        // Random settings with no idling on either side.
        set_up({$urandom, $urandom}, {$urandom, $urandom}, SIZE_W'($urandom_range(1, 4096)),
               1'($urandom), 1'b1, COUNT_W'($urandom_range(2, 40)), 0, 0);
        repeat (150) queue_random();
        settle();

        // New bases and stride over the pool left in place.
        set_up({$urandom, $urandom}, {$urandom, $urandom}, SIZE_W'($urandom_range(1, 4096)),
               1'($urandom), 1'b0, '0, 0, 0);
        repeat (150) queue_random();
        settle();

        if (mismatches == 0 && due_replies.size() == 0)
            $display("descriptor_slot_allocator_test OK");
        else
            $display("descriptor_slot_allocator_test NOT OK");
        $finish;
    end

endmodule
